FILE: hdl/indexed_array_list_core_defines.svh
// ----------------------------------------------------------------------------
// Indexed array list assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_ARRAY_LIST_CORE_DEFINES_SVH
`define INDEXED_ARRAY_LIST_CORE_DEFINES_SVH

// same-cycle implication
`define IAC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IAC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/iac_pkg.sv
// ----------------------------------------------------------------------------
// Indexed array list package
// Sizes, codes and transaction types shared by the list core and its cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iac_pkg;

   localparam int DEPTH = 16;
   localparam int WIDTH = 32;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef logic signed [WIDTH-1:0] word_type;

   typedef enum logic [2:0] {
      MODE_APPEND     = 3'd0,
      MODE_INSERT     = 3'd1,
      MODE_REMOVE_AT  = 3'd2,
      MODE_REMOVE_VAL = 3'd3,
      MODE_READ       = 3'd4,
      MODE_FIND       = 3'd5,
      MODE_CLEAR      = 3'd6
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_RANGE    = 2'd1,
      STAT_FULL     = 2'd2,
      STAT_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2
   } cell_op_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic [2:0]       mode;
      logic [CNT_W-1:0] position;
      word_type         value;
   } req_type;

   typedef struct packed {
      status_type       status;
      word_type         item;
      logic [IDX_W-1:0] found_at;
      logic [CNT_W-1:0] length;
      logic             is_empty;
   } rsp_type;

   typedef struct packed {
      cell_op_type      op;
      logic [IDX_W-1:0] at;
      word_type         value;
      logic             cmp_en;
      logic [CNT_W-1:0] count;
   } cell_cmd_type;

endpackage

FILE: hdl/iac_cell.sv
// ----------------------------------------------------------------------------
// Indexed array list cell
// Holds one entry; insert loads or shifts it, remove shifts it; flags a match.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iac_cell (
   input  logic                      clock,
   input  logic [iac_pkg::IDX_W-1:0] cell_idx,
   input  iac_pkg::cell_cmd_type     cmd,
   input  iac_pkg::word_type         lower_data,
   input  iac_pkg::word_type         upper_data,
   output iac_pkg::word_type         data,
   output logic                      match
);

   iac_pkg::word_type data_ff, data_in;
   logic              match_ff, match_in;

   always_comb begin
      data_in = data_ff;
      unique case (cmd.op)
         iac_pkg::CELL_INSERT: begin
            if (cell_idx > cmd.at) begin
               data_in = lower_data;
            end else if (cell_idx == cmd.at) begin
               data_in = cmd.value;
            end
         end
         iac_pkg::CELL_REMOVE: begin
            if (cell_idx >= cmd.at) begin
               data_in = upper_data;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_comb begin
      match_in = match_ff;
      if (cmd.cmp_en) begin
         match_in = (data_ff == cmd.value) && (iac_pkg::CNT_W'(cell_idx) < cmd.count);
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
   end

   assign data  = data_ff;
   assign match = match_ff;

endmodule

FILE: hdl/indexed_array_list_core.sv
// ----------------------------------------------------------------------------
// Indexed array list core
// Ordered list of signed words with append, insert, remove, read, find, clear.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_stall/req_data carry one request transaction (mode,
//   position, value). rsp_valid/rsp_stall/rsp_data carry one result
//   transaction per request (status, item, found_at, length, is_empty).
//   When a request is taken, every cell registers a compare of its entry
//   against the request value; the execute state then runs the operation
//   across the cell chain (all entries shift together) and loads the
//   result register once it is free. Each request passes a compare step
//   and then an execute step; no new request is taken until execute ends.
//   A new request is taken while a finished result waits in the output
//   register; the execute cycle holds until that register is free, so a
//   stalled receiver stalls the request side after at most one request.
//   Reset empties the list and drops any pending result; entry contents
//   are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "indexed_array_list_core_defines.svh"

module indexed_array_list_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  iac_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output iac_pkg::rsp_type rsp_data
);

   iac_pkg::state_type     state_ff, state_in;
   iac_pkg::req_type       req_ff, req_in;
   iac_pkg::rsp_type       rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [iac_pkg::CNT_W-1:0] used_ff, used_in, used_next;

   iac_pkg::cell_cmd_type  cmd;
   iac_pkg::word_type      cell_data [iac_pkg::DEPTH];
   logic [iac_pkg::DEPTH-1:0] match_vec;
   logic                   req_accept;
   logic                   exec_go;
   logic                   hit_any;
   logic [iac_pkg::IDX_W-1:0] hit_idx;
   logic [iac_pkg::IDX_W-1:0] pos_idx;
   logic                   full;

   assign req_accept = req_valid && !req_stall;

   // state machine: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         iac_pkg::S_IDLE: if (req_accept) state_in = iac_pkg::S_EXEC;
         iac_pkg::S_EXEC: if (exec_go) state_in = iac_pkg::S_IDLE;
         default:         state_in = iac_pkg::S_IDLE;
      endcase
   end

   // state machine: outputs
   always_comb begin
      req_stall = 1'b0;
      exec_go   = 1'b0;
      unique case (state_ff)
         iac_pkg::S_IDLE: req_stall = 1'b0;
         iac_pkg::S_EXEC: begin
            req_stall = 1'b1;
            exec_go   = !rsp_valid_ff || !rsp_stall;
         end
         default: req_stall = 1'b1;
      endcase
   end

   always_comb begin
      hit_any = |match_vec;
      hit_idx = '0;
      for (int i = iac_pkg::DEPTH - 1; i >= 0; i--) begin
         if (match_vec[i]) hit_idx = iac_pkg::IDX_W'(i);
      end
   end

   assign pos_idx = req_ff.position[iac_pkg::IDX_W-1:0];
   assign full    = (used_ff == iac_pkg::CNT_W'(iac_pkg::DEPTH));
   assign req_in  = req_accept ? req_data : req_ff;

   always_comb begin
      cmd.op     = iac_pkg::CELL_HOLD;
      cmd.at     = '0;
      cmd.value  = req_accept ? req_data.value : req_ff.value;
      cmd.cmp_en = req_accept;
      cmd.count  = used_ff;
      used_next       = used_ff;
      rsp_in.status   = iac_pkg::STAT_OK;
      rsp_in.item     = '0;
      rsp_in.found_at = '0;
      if (exec_go) begin
         unique case (req_ff.mode)
            iac_pkg::MODE_APPEND: begin
               if (full) begin
                  rsp_in.status = iac_pkg::STAT_FULL;
               end else begin
                  cmd.op    = iac_pkg::CELL_INSERT;
                  cmd.at    = used_ff[iac_pkg::IDX_W-1:0];
                  used_next = used_ff + 1'b1;
               end
            end
            iac_pkg::MODE_INSERT: begin
               if (req_ff.position > used_ff) begin
                  rsp_in.status = iac_pkg::STAT_RANGE;
               end else if (full) begin
                  rsp_in.status = iac_pkg::STAT_FULL;
               end else begin
                  cmd.op    = iac_pkg::CELL_INSERT;
                  cmd.at    = pos_idx;
                  used_next = used_ff + 1'b1;
               end
            end
            iac_pkg::MODE_REMOVE_AT: begin
               if (req_ff.position >= used_ff) begin
                  rsp_in.status = iac_pkg::STAT_RANGE;
               end else begin
                  cmd.op      = iac_pkg::CELL_REMOVE;
                  cmd.at      = pos_idx;
                  rsp_in.item = cell_data[pos_idx];
                  used_next   = used_ff - 1'b1;
               end
            end
            iac_pkg::MODE_REMOVE_VAL: begin
               if (!hit_any) begin
                  rsp_in.status = iac_pkg::STAT_NOTFOUND;
               end else begin
                  cmd.op          = iac_pkg::CELL_REMOVE;
                  cmd.at          = hit_idx;
                  rsp_in.item     = cell_data[hit_idx];
                  rsp_in.found_at = hit_idx;
                  used_next       = used_ff - 1'b1;
               end
            end
            iac_pkg::MODE_READ: begin
               if (req_ff.position >= used_ff) begin
                  rsp_in.status = iac_pkg::STAT_RANGE;
               end else begin
                  rsp_in.item = cell_data[pos_idx];
               end
            end
            iac_pkg::MODE_FIND: begin
               if (!hit_any) begin
                  rsp_in.status = iac_pkg::STAT_NOTFOUND;
               end else begin
                  rsp_in.found_at = hit_idx;
               end
            end
            iac_pkg::MODE_CLEAR: used_next = '0;
            default:             used_next = used_ff;
         endcase
      end
      rsp_in.length   = used_next;
      rsp_in.is_empty = (used_next == '0);
   end

   assign used_in      = used_next;
   assign rsp_valid_in = exec_go || (rsp_valid_ff && rsp_stall);

   genvar g;
   generate
      for (g = 0; g < iac_pkg::DEPTH; g++) begin : g_cell
         iac_pkg::word_type lower_w, upper_w;
         if (g == 0) begin : g_first
            assign lower_w = cmd.value;
         end else begin : g_mid_lo
            assign lower_w = cell_data[g-1];
         end
         if (g == iac_pkg::DEPTH - 1) begin : g_last
            assign upper_w = '0;
         end else begin : g_mid_hi
            assign upper_w = cell_data[g+1];
         end
         iac_cell u_cell (
            .clock      (clock),
            .cell_idx   (iac_pkg::IDX_W'(g)),
            .cmd        (cmd),
            .lower_data (lower_w),
            .upper_data (upper_w),
            .data       (cell_data[g]),
            .match      (match_vec[g])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iac_pkg::S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      if (exec_go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `IAC_ASSERT_NXT(a_accept_exec, req_accept, state_ff == iac_pkg::S_EXEC, "accepted transaction did not enter execute")
   `IAC_ASSERT_NXT(a_exec_result, exec_go, rsp_valid_ff && (rsp_ff.length == used_ff), "result length does not match list count")
   `IAC_ASSERT_IMP(a_count_bound, 1'b1, used_ff <= iac_pkg::CNT_W'(iac_pkg::DEPTH), "list count exceeds depth")

endmodule
